[src/wf3_pkg.sv]
// Package for the 3x3 window filter: item types, register indexes, mode codes
// and the per-neighbor merge function.
// No dependencies; window_filter_3x3, wf3_col_cell and the testbench import it.
`default_nettype none

package wf3_pkg;

  // One input item: a pixel or a drain request.
  typedef struct packed {
    logic       action;
    logic [7:0] pixel;
  } in_item_t;

  // One result item.
  typedef struct packed {
    logic signed [19:0] value;
    logic [9:0]         out_col;
    logic [15:0]        out_row;
    logic               frame_last;
  } out_item_t;

  // Input actions.
  localparam logic ACT_PIXEL = 1'b0;
  localparam logic ACT_DRAIN = 1'b1;

  // Register indexes of the configuration port.
  localparam logic [2:0] CFG_MERGE_MODE    = 3'd0;
  localparam logic [2:0] CFG_REDUCE_MODE   = 3'd1;
  localparam logic [2:0] CFG_IMAGE_WIDTH   = 3'd2;
  localparam logic [2:0] CFG_IMAGE_HEIGHT  = 3'd3;
  localparam logic [2:0] CFG_KERNEL_TOP    = 3'd4;
  localparam logic [2:0] CFG_KERNEL_MIDDLE = 3'd5;
  localparam logic [2:0] CFG_KERNEL_BOTTOM = 3'd6;

  // Merge modes; any other code multiplies.
  localparam logic [1:0] MERGE_MUL = 2'd0;
  localparam logic [1:0] MERGE_ADD = 2'd1;
  localparam logic [1:0] MERGE_SUB = 2'd2;

  // Reduce modes; any other code sums.
  localparam logic [2:0] REDUCE_SUM    = 3'd0;
  localparam logic [2:0] REDUCE_MAX    = 3'd1;
  localparam logic [2:0] REDUCE_MIN    = 3'd2;
  localparam logic [2:0] REDUCE_MEAN   = 3'd3;
  localparam logic [2:0] REDUCE_MEDIAN = 3'd4;

  // Division by nine as multiply by a rounded-up reciprocal; exact below 2^21.
  localparam int unsigned MEAN_MUL   = 466034;
  localparam int unsigned MEAN_SHIFT = 22;

  // Rank positions in a sorted set of nine.
  localparam logic [3:0] RANK_MIN    = 4'd0;
  localparam logic [3:0] RANK_MEDIAN = 4'd4;
  localparam logic [3:0] RANK_MAX    = 4'd8;

  // One window column, index 0 is the top row.
  typedef logic [2:0][7:0] pix_col_t;

  // A merged neighbor value and the sum of nine of them.
  typedef logic signed [16:0] mval_t;
  typedef logic signed [19:0] msum_t;

  // Merge one pixel with its signed coefficient.
  function automatic mval_t merge_px(logic [1:0] mode, logic [7:0] p, logic signed [7:0] k);
    mval_t ps;
    mval_t ks;
    ps = mval_t'(signed'({1'b0, p}));
    ks = mval_t'(k);
    unique case (mode)
      MERGE_ADD: return ps + ks;
      MERGE_SUB: return ps - ks;
      default:   return ps * ks;
    endcase
  endfunction

endpackage

`default_nettype wire

[src/window_filter_3x3.sv]
// 3x3 neighborhood filter over an 8-bit raster pixel stream. The block takes
// one item per clock while in_ready is high: a pixel, or a drain that pushes a
// zero dummy pixel through the window. A drain that needs two dummy pixels
// (tiny frames, or a frame whose pending results do not line up) holds in_ready
// low while the first dummy pixel is shifted in. A result passes the snapshot,
// merge, rank/sum and output registers (select/mean feeds the output register),
// and items keep entering while a result waits until those stages fill.
// After reset and after every configuration write, in_ready stays low while
// the frame positions are recomputed with the row-times-width multipliers. The
// two line stores are RAMs without a clearing pass; entries never written only
// feed neighbors outside the image.
`default_nettype none

module window_filter_3x3
  import wf3_pkg::*;
#(
  parameter int MAX_WIDTH = 1024
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire in_item_t  in_data,
  output logic           out_valid,
  input  wire logic      out_ready,
  output out_item_t      out_data,
  input  wire logic      cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [23:0] cfg_data
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int RW = 17;
  localparam int HW = 16 + WW;
  localparam int QW = RW + WW + 1;

  typedef struct packed {
    logic [9:0]  out_col;
    logic [15:0] out_row;
    logic        frame_last;
  } meta_t;

  // Configuration registers.
  logic [1:0]  merge_mode_r;
  logic [2:0]  reduce_mode_r;
  logic [10:0] image_width_r;
  logic [15:0] image_height_r;
  logic [23:0] kern_r [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      merge_mode_r   <= MERGE_MUL;
      reduce_mode_r  <= REDUCE_SUM;
      image_width_r  <= 11'd640;
      image_height_r <= 16'd480;
      kern_r[0]      <= 24'h000000;
      kern_r[1]      <= 24'h000100;
      kern_r[2]      <= 24'h000000;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_MERGE_MODE:    merge_mode_r   <= cfg_data[1:0];
        CFG_REDUCE_MODE:   reduce_mode_r  <= cfg_data[2:0];
        CFG_IMAGE_WIDTH:   image_width_r  <= cfg_data[10:0];
        CFG_IMAGE_HEIGHT:  image_height_r <= cfg_data[15:0];
        CFG_KERNEL_TOP:    kern_r[0]      <= cfg_data;
        CFG_KERNEL_MIDDLE: kern_r[1]      <= cfg_data;
        CFG_KERNEL_BOTTOM: kern_r[2]      <= cfg_data;
        default: ;
      endcase
    end
  end

  // Effective frame sizes.
  logic [WW-1:0] eff_w;
  logic [15:0]   eff_h;

  always_comb begin
    if (image_width_r == '0) begin
      eff_w = WW'(1);
    end else if (32'(image_width_r) > MAX_WIDTH) begin
      eff_w = WW'(MAX_WIDTH);
    end else begin
      eff_w = WW'(image_width_r);
    end
    eff_h = (image_height_r == '0) ? 16'd1 : image_height_r;
  end

  // Position state.
  logic [CW-1:0] in_col_r, in_col_nxt;
  logic [RW-1:0] in_row_r, in_row_nxt;
  logic [CW-1:0] out_col_r, out_col_nxt;
  logic [RW-1:0] out_row_r, out_row_nxt;
  logic [QW-1:0] qin_r, qin_nxt;
  logic [QW-1:0] qout_r, qout_nxt;
  logic [1:0]    recalc_r;
  logic          second_r;

  // Linear positions are rebuilt after reset and configuration writes.
  logic [QW-1:0] p_in_r, p_out_r;
  logic [HW-1:0] hw_r;

  always_ff @(posedge clk) begin
    p_in_r  <= QW'(in_row_r) * QW'(eff_w);
    p_out_r <= QW'(out_row_r) * QW'(eff_w);
    hw_r    <= HW'(eff_h) * HW'(eff_w);
  end

  // Line store read data with write bypass.
  logic [7:0] upper_q, lower_q, up2, up1;
  logic       byp_r;
  logic [7:0] byp_upper_r, byp_lower_r;

  assign up2 = byp_r ? byp_upper_r : upper_q;
  assign up1 = byp_r ? byp_lower_r : lower_q;

  // Shift and emit decisions for the item at the input.
  logic          busy, frame_in, is_drain, shift_ok, preshift, acc, do_shift, emit;
  logic [7:0]    shift_pix;
  logic          col_wrap, ocol_wrap, last;
  logic [CW-1:0] col1;
  logic [RW-1:0] row1;
  logic [QW-1:0] qin1;
  logic signed [QW:0] qdiff;
  logic          emit1;
  logic          rdy1, rdy2, rdy3, rdy4;

  assign busy     = (recalc_r != 2'd0);
  assign frame_in = (in_row_r >= RW'(eff_h));
  assign is_drain = (in_data.action == ACT_DRAIN);
  assign shift_ok = is_drain ? frame_in : !frame_in;
  assign shift_pix = is_drain ? 8'd0 : in_data.pixel;

  always_comb begin
    col_wrap = ((WW+1)'(in_col_r) + (WW+1)'(1)) >= (WW+1)'(eff_w);
    if (col_wrap) begin
      col1 = '0;
      row1 = in_row_r + RW'(1);
      qin1 = qin_r - QW'(in_col_r) + QW'(eff_w);
    end else begin
      col1 = in_col_r + CW'(1);
      row1 = in_row_r;
      qin1 = qin_r + QW'(1);
    end
    qdiff = signed'({1'b0, qin1}) - signed'({1'b0, qout_r});
    emit1 = qdiff >= signed'((QW+1)'(eff_w) + (QW+1)'(2));
    ocol_wrap = ((WW+1)'(out_col_r) + (WW+1)'(1)) >= (WW+1)'(eff_w);
    last = ((QW+1)'(qout_r) + (QW+1)'(1)) >= (QW+1)'(hw_r);
  end

  assign preshift = in_valid && !busy && is_drain && frame_in && !second_r && !emit1;
  assign in_ready = !busy && rdy1 && !preshift;
  assign acc      = in_valid && in_ready;
  assign do_shift = (acc && shift_ok) || preshift;
  assign emit     = acc && shift_ok && emit1;

  // Next position state.
  always_comb begin
    in_col_nxt  = in_col_r;
    in_row_nxt  = in_row_r;
    out_col_nxt = out_col_r;
    out_row_nxt = out_row_r;
    qin_nxt     = qin_r;
    qout_nxt    = qout_r;
    if (recalc_r == 2'd1) begin
      qin_nxt  = p_in_r + QW'(in_col_r);
      qout_nxt = p_out_r + QW'(out_col_r);
    end
    if (do_shift) begin
      in_col_nxt = col1;
      in_row_nxt = row1;
      qin_nxt    = qin1;
    end
    if (emit) begin
      if (last) begin
        in_col_nxt  = '0;
        in_row_nxt  = '0;
        out_col_nxt = '0;
        out_row_nxt = '0;
        qin_nxt     = '0;
        qout_nxt    = '0;
      end else if (ocol_wrap) begin
        out_col_nxt = '0;
        out_row_nxt = out_row_r + RW'(1);
        qout_nxt    = qout_r - QW'(out_col_r) + QW'(eff_w);
      end else begin
        out_col_nxt = out_col_r + CW'(1);
        qout_nxt    = qout_r + QW'(1);
      end
    end
    if (!rst_n) begin
      in_col_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_col_r  <= '0;
      in_row_r  <= '0;
      out_col_r <= '0;
      out_row_r <= '0;
      qin_r     <= '0;
      qout_r    <= '0;
      recalc_r  <= 2'd2;
      second_r  <= 1'b0;
      byp_r     <= 1'b0;
    end else begin
      in_col_r  <= in_col_nxt;
      in_row_r  <= in_row_nxt;
      out_col_r <= out_col_nxt;
      out_row_r <= out_row_nxt;
      qin_r     <= qin_nxt;
      qout_r    <= qout_nxt;
      if (cfg_we) begin
        recalc_r <= 2'd2;
      end else if (busy) begin
        recalc_r <= recalc_r - 2'd1;
      end
      if (preshift) begin
        second_r <= 1'b1;
      end else if (acc) begin
        second_r <= 1'b0;
      end
      byp_r <= do_shift && (in_col_r == in_col_nxt);
    end
  end

  always_ff @(posedge clk) begin
    byp_upper_r <= up1;
    byp_lower_r <= shift_pix;
  end

  // Line stores: the upper row takes what leaves the lower one.
  wf3_ram #(.DW(8), .DEPTH(MAX_WIDTH)) u_upper (
    .clk   (clk),
    .we    (do_shift),
    .waddr (in_col_r),
    .wdata (up1),
    .raddr (in_col_nxt),
    .rdata (upper_q)
  );

  wf3_ram #(.DW(8), .DEPTH(MAX_WIDTH)) u_lower (
    .clk   (clk),
    .we    (do_shift),
    .waddr (in_col_r),
    .wdata (shift_pix),
    .raddr (in_col_nxt),
    .rdata (lower_q)
  );

  // Window: three column cells, each taking its right neighbor's column.
  pix_col_t new_col;
  pix_col_t cell_q [3];

  assign new_col = {shift_pix, up1, up2};

  wf3_col_cell u_cell0 (.clk(clk), .rst_n(rst_n), .shift_en(do_shift),
                        .col_in(cell_q[1]), .col_q(cell_q[0]));
  wf3_col_cell u_cell1 (.clk(clk), .rst_n(rst_n), .shift_en(do_shift),
                        .col_in(cell_q[2]), .col_q(cell_q[1]));
  wf3_col_cell u_cell2 (.clk(clk), .rst_n(rst_n), .shift_en(do_shift),
                        .col_in(new_col), .col_q(cell_q[2]));

  // In-image flags of the nine neighbors of the next result.
  logic [2:0] row_ok, col_ok;
  logic [8:0] mask;

  always_comb begin
    row_ok[0] = (out_row_r != '0) && ((out_row_r - RW'(1)) < RW'(eff_h));
    row_ok[1] = out_row_r < RW'(eff_h);
    row_ok[2] = ((RW+1)'(out_row_r) + (RW+1)'(1)) < (RW+1)'(eff_h);
    col_ok[0] = (out_col_r != '0) && ((WW+1)'(out_col_r - CW'(1)) < (WW+1)'(eff_w));
    col_ok[1] = (WW+1)'(out_col_r) < (WW+1)'(eff_w);
    col_ok[2] = ((WW+1)'(out_col_r) + (WW+1)'(1)) < (WW+1)'(eff_w);
    for (int j = 0; j < 3; j++) begin
      for (int k = 0; k < 3; k++) begin
        mask[j*3+k] = row_ok[j] && col_ok[k];
      end
    end
  end

  // Pipeline flow: each stage moves when the one after it has room.
  logic v1_r, v2_r, v3_r, v4_r;

  assign rdy4 = !v4_r || out_ready;
  assign rdy3 = !v3_r || rdy4;
  assign rdy2 = !v2_r || rdy3;
  assign rdy1 = !v1_r || rdy2;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= emit;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
      if (rdy4) v4_r <= v3_r;
    end
  end

  // Stage 1: window snapshot after the shift.
  logic [2:0][2:0][7:0] s1_pix_r;
  logic [8:0]           s1_mask_r;
  meta_t                s1_meta_r;

  always_ff @(posedge clk) begin
    if (rdy1) begin
      for (int j = 0; j < 3; j++) begin
        s1_pix_r[j][0] <= cell_q[1][j];
        s1_pix_r[j][1] <= cell_q[2][j];
        s1_pix_r[j][2] <= new_col[j];
      end
      s1_mask_r <= mask;
      s1_meta_r <= '{out_col: 10'(out_col_r), out_row: 16'(out_row_r), frame_last: last};
    end
  end

  // Stage 2: merge each neighbor with its coefficient.
  mval_t m2_r [9];
  meta_t s2_meta_r;

  always_ff @(posedge clk) begin
    if (rdy2) begin
      for (int j = 0; j < 3; j++) begin
        for (int k = 0; k < 3; k++) begin
          m2_r[j*3+k] <= s1_mask_r[j*3+k]
                         ? merge_px(merge_mode_r, s1_pix_r[j][k], kern_r[j][k*8 +: 8])
                         : mval_t'(0);
        end
      end
      s2_meta_r <= s1_meta_r;
    end
  end

  // Stage 3: sum and the rank of each value, ties broken by position.
  mval_t      m3_r [9];
  logic [3:0] rank3_r [9];
  msum_t      sum3_r;
  meta_t      s3_meta_r;
  msum_t      sum2;
  logic [8:0] below [9];

  always_comb begin
    sum2 = '0;
    for (int i = 0; i < 9; i++) begin
      sum2 = sum2 + msum_t'(m2_r[i]);
      for (int j = 0; j < 9; j++) begin
        below[i][j] = (j != i) && ((m2_r[j] < m2_r[i]) || ((m2_r[j] == m2_r[i]) && (j < i)));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy3) begin
      for (int i = 0; i < 9; i++) begin
        m3_r[i]    <= m2_r[i];
        rank3_r[i] <= 4'($countones(below[i]));
      end
      sum3_r    <= sum2;
      s3_meta_r <= s2_meta_r;
    end
  end

  // Stage 4: pick by rank, divide the sum by nine, or pass the sum, into the output register.
  logic [3:0]  want_rank;
  mval_t       picked;
  logic [18:0] sum_abs;
  logic [37:0] mean_prod;
  msum_t       mean_q, result;
  out_item_t   out_r;

  always_comb begin
    unique case (reduce_mode_r)
      REDUCE_MAX: want_rank = RANK_MAX;
      REDUCE_MIN: want_rank = RANK_MIN;
      default:    want_rank = RANK_MEDIAN;
    endcase
    picked = '0;
    for (int i = 0; i < 9; i++) begin
      if (rank3_r[i] == want_rank) picked = picked | m3_r[i];
    end
    sum_abs   = sum3_r[19] ? 19'(-sum3_r) : sum3_r[18:0];
    mean_prod = 38'(sum_abs) * 38'(MEAN_MUL);
    mean_q    = msum_t'(mean_prod[MEAN_SHIFT +: 16]);
    if (sum3_r[19]) mean_q = -mean_q;
    unique case (reduce_mode_r)
      REDUCE_MAX, REDUCE_MIN, REDUCE_MEDIAN: result = msum_t'(picked);
      REDUCE_MEAN: result = mean_q;
      default:     result = sum3_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rdy4) begin
      out_r <= '{value: result, out_col: s3_meta_r.out_col,
                 out_row: s3_meta_r.out_row, frame_last: s3_meta_r.frame_last};
    end
  end

  assign out_valid = v4_r;
  assign out_data  = out_r;

endmodule

`default_nettype wire

[src/wf3_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies; used for both line stores of the window filter.
`default_nettype none

module wf3_ram #(
  parameter int DW    = 8,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [DW-1:0]            wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [DW-1:0]            rdata
);

  logic [DW-1:0] mem [DEPTH];

  // Write port and registered read port; a read of the address being written
  // returns the old contents.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

[src/wf3_col_cell.sv]
// One column cell of the 3x3 window: holds three pixels and takes the column
// of its right neighbor on every shift. Depends on wf3_pkg.
`default_nettype none

module wf3_col_cell
  import wf3_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     shift_en,
  input  wire pix_col_t col_in,
  output pix_col_t      col_q
);

  pix_col_t col_r;

  // Column register, cleared by reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
    end else if (shift_en) begin
      col_r <= col_in;
    end
  end

  assign col_q = col_r;

endmodule

`default_nettype wire

[tb/tb_window_filter_3x3.sv]
// Self-checking testbench for window_filter_3x3: a queue-fed driver, a result monitor
// and a local 3x3 window predictor checked item by item.
// Depends on wf3_pkg and window_filter_3x3 only.
`timescale 1ns / 1ps
`default_nettype none

module tb_window_filter_3x3;
  import wf3_pkg::*;

  localparam int LINE_MAX = 1024;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  in_item_t    in_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_item_t   out_data;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [23:0] cfg_data = '0;

  window_filter_3x3 i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #10 clk = ~clk;

  // Predictor state: registers, line stores, window and frame positions.
  logic [1:0]  p_merge;
  logic [2:0]  p_reduce;
  logic [10:0] p_width;
  logic [15:0] p_height;
  logic [23:0] p_kern [3];
  logic [7:0]  row_up [LINE_MAX];
  logic [7:0]  row_lo [LINE_MAX];
  logic [7:0]  win [9];
  int          col_in, row_in, col_out, row_out;

  in_item_t    pixel_queue[$];
  out_item_t   window_results[$];
  int          fail_count = 0;
  int          gap_left = 0;
  int          stall_left = 0;
  bit          quiet = 1'b0;
  int          real_items = 0;

  function automatic int width_eff();
    if (p_width == 0) return 1;
    if (p_width > LINE_MAX) return LINE_MAX;
    return int'(p_width);
  endfunction

  function automatic int height_eff();
    return (p_height == 0) ? 1 : int'(p_height);
  endfunction

  // Shift one pixel into the window and the line stores.
  function automatic void shift_pixel(logic [7:0] pix);
    logic [7:0] up2, up1;
    int c;
    c = col_in % LINE_MAX;
    up2 = row_up[c];
    up1 = row_lo[c];
    row_up[c] = up1;
    row_lo[c] = pix;
    for (int j = 0; j < 3; j++) begin
      win[j*3] = win[j*3+1];
      win[j*3+1] = win[j*3+2];
    end
    win[2] = up2;
    win[5] = up1;
    win[8] = pix;
    col_in++;
    if (col_in >= width_eff()) begin
      col_in = 0;
      row_in++;
    end
  endfunction

  // Produce the centre result once its lower-right neighbor is in.
  function automatic bit window_result(output out_item_t res);
    longint w, h, qin, qout;
    int vals [9];
    int acc, n, p, k, t, j, rr, cc;
    bit last;
    w = width_eff();
    h = height_eff();
    qin = longint'(row_in) * w + col_in;
    qout = longint'(row_out) * w + col_out;
    res = '0;
    if (qin - qout < w + 2) return 1'b0;
    n = 0;
    for (int dy = -1; dy <= 1; dy++) begin
      for (int dx = -1; dx <= 1; dx++) begin
        rr = row_out + dy;
        cc = col_out + dx;
        vals[n] = 0;
        if (rr >= 0 && rr < h && cc >= 0 && cc < w) begin
          p = int'(win[(dy+1)*3 + dx + 1]);
          k = int'($signed(p_kern[dy+1][8*(dx+1) +: 8]));
          case (p_merge)
            MERGE_ADD: vals[n] = p + k;
            MERGE_SUB: vals[n] = p - k;
            default:   vals[n] = p * k;
          endcase
        end
        n++;
      end
    end
    acc = 0;
    case (p_reduce)
      REDUCE_MAX: begin
        acc = vals[0];
        for (int i = 1; i < 9; i++) if (vals[i] > acc) acc = vals[i];
      end
      REDUCE_MIN: begin
        acc = vals[0];
        for (int i = 1; i < 9; i++) if (vals[i] < acc) acc = vals[i];
      end
      REDUCE_MEDIAN: begin
        for (int i = 1; i < 9; i++) begin
          t = vals[i];
          j = i - 1;
          while (j >= 0 && vals[j] > t) begin
            vals[j+1] = vals[j];
            j--;
          end
          vals[j+1] = t;
        end
        acc = vals[4];
      end
      default: begin
        for (int i = 0; i < 9; i++) acc += vals[i];
        if (p_reduce == REDUCE_MEAN) acc = acc / 9;
      end
    endcase
    last = (qout >= h * w - 1);
    res.value = acc[19:0];
    res.out_col = col_out[9:0];
    res.out_row = row_out[15:0];
    res.frame_last = last;
    if (last) begin
      col_in = 0; row_in = 0; col_out = 0; row_out = 0;
    end else begin
      col_out++;
      if (col_out >= w) begin
        col_out = 0;
        row_out++;
      end
    end
    return 1'b1;
  endfunction

  // Update the predictor for one accepted item.
  function automatic void predict_item(in_item_t it);
    out_item_t r;
    bit done;
    done = (row_in >= height_eff());
    if (it.action == ACT_PIXEL) begin
      if (done) return;
      shift_pixel(it.pixel);
      if (window_result(r)) window_results.push_back(r);
    end else begin
      if (!done) return;
      shift_pixel(8'd0);
      if (window_result(r)) begin
        window_results.push_back(r);
        return;
      end
      shift_pixel(8'd0);
      if (window_result(r)) window_results.push_back(r);
    end
  endfunction

  // Driver: accept, predict, then present the next item or idle.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) predict_item(in_data);
      if (!in_valid || in_ready) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          in_valid <= 1'b0;
        end else if (pixel_queue.size() > 0) begin
          in_valid <= 1'b1;
          in_data <= pixel_queue.pop_front();
          if (!quiet && $urandom_range(0, 6) == 0) gap_left <= $urandom_range(1, 11);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver back-pressure in random bursts.
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready <= 1'b0;
    end else if (!quiet && $urandom_range(0, 6) == 0) begin
      stall_left <= $urandom_range(0, 10);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Monitor: compare each result with the oldest prediction.
  always @(posedge clk) begin
    out_item_t e;
    if (rst_n && out_valid && out_ready) begin
      if (window_results.size() == 0) begin
        $error("unexpected result item %p", out_data);
        fail_count++;
      end else begin
        e = window_results.pop_front();
        if (out_data.value !== e.value) begin
          $error("value: expected %0d, got %0d", e.value, out_data.value);
          fail_count++;
        end
        if (out_data.out_col !== e.out_col) begin
          $error("out_col: expected %0d, got %0d", e.out_col, out_data.out_col);
          fail_count++;
        end
        if (out_data.out_row !== e.out_row) begin
          $error("out_row: expected %0d, got %0d", e.out_row, out_data.out_row);
          fail_count++;
        end
        if (out_data.frame_last !== e.frame_last) begin
          $error("frame_last: expected %0d, got %0d", e.frame_last, out_data.frame_last);
          fail_count++;
        end
      end
    end
  end

  // Wait until every item is in and every result is out, then let the pipe settle.
  task automatic wait_idle();
    while (pixel_queue.size() > 0 || in_valid || gap_left > 0 || window_results.size() > 0)
      @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [23:0] v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    case (idx)
      CFG_MERGE_MODE:    p_merge = v[1:0];
      CFG_REDUCE_MODE:   p_reduce = v[2:0];
      CFG_IMAGE_WIDTH:   p_width = v[10:0];
      CFG_IMAGE_HEIGHT:  p_height = v[15:0];
      CFG_KERNEL_TOP:    p_kern[0] = v;
      CFG_KERNEL_MIDDLE: p_kern[1] = v;
      default:           p_kern[2] = v;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic setup(input logic [1:0] m, input logic [2:0] r, input logic [10:0] w,
                       input logic [15:0] h, input logic [23:0] kt, input logic [23:0] km,
                       input logic [23:0] kb);
    wait_idle();
    write_reg(CFG_MERGE_MODE, 24'(m));
    write_reg(CFG_REDUCE_MODE, 24'(r));
    write_reg(CFG_IMAGE_WIDTH, 24'(w));
    write_reg(CFG_IMAGE_HEIGHT, 24'(h));
    write_reg(CFG_KERNEL_TOP, kt);
    write_reg(CFG_KERNEL_MIDDLE, km);
    write_reg(CFG_KERNEL_BOTTOM, kb);
  endtask

  // Queue one frame of random pixels, with occasional early drains, then its drains
  // with occasional stray pixels that arrive after the frame end.
  task automatic queue_frame(input bit noisy);
    in_item_t it;
    int n;
    n = width_eff() * height_eff();
    for (int i = 0; i < n; i++) begin
      if (noisy && $urandom_range(0, 15) == 0) begin
        it.action = ACT_DRAIN;
        it.pixel = 8'($urandom);
        pixel_queue.push_back(it);
      end
      it.action = ACT_PIXEL;
      it.pixel = ($urandom_range(0, 5) == 0) ? ($urandom_range(0, 1) ? 8'hFF : 8'h00)
                                             : 8'($urandom);
      pixel_queue.push_back(it);
    end
    for (int i = 0; i < width_eff() + 2; i++) begin
      if (noisy && $urandom_range(0, 9) == 0) begin
        it.action = ACT_PIXEL;
        it.pixel = 8'($urandom);
        pixel_queue.push_back(it);
      end
      it.action = ACT_DRAIN;
      it.pixel = 8'($urandom);
      pixel_queue.push_back(it);
    end
    real_items += n + width_eff() + 1;
  endtask

  initial begin
    in_item_t it;
    p_merge = '0; p_reduce = '0; p_width = 11'd640; p_height = 16'd480;
    p_kern[0] = 24'h0; p_kern[1] = 24'h000100; p_kern[2] = 24'h0;
    for (int i = 0; i < LINE_MAX; i++) begin
      row_up[i] = '0;
      row_lo[i] = '0;
    end
    for (int i = 0; i < 9; i++) win[i] = '0;
    col_in = 0; row_in = 0; col_out = 0; row_out = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: 3x3 frame with extreme pixels and coefficients, median reduce.
    setup(MERGE_MUL, REDUCE_MEDIAN, 11'd3, 16'd3, 24'h807F80, 24'h7F807F, 24'h01FF80);
    it.action = ACT_DRAIN;
    it.pixel = 8'hFF;
    pixel_queue.push_back(it);
    for (int i = 0; i < 9; i++) begin
      it.action = ACT_PIXEL;
      it.pixel = (i % 2) ? 8'hFF : 8'h00;
      pixel_queue.push_back(it);
    end
    for (int i = 0; i < 5; i++) begin
      it.action = ACT_DRAIN;
      it.pixel = 8'h00;
      pixel_queue.push_back(it);
    end
    // Zero sizes act as one pixel; unknown modes fall back to multiply and sum.
    setup(2'd3, 3'd7, 11'd0, 16'd0, 24'hFFFFFF, 24'h007F00, 24'h000000);
    it.action = ACT_PIXEL;
    it.pixel = 8'hFF;
    pixel_queue.push_back(it);
    pixel_queue.push_back(it);
    it.action = ACT_DRAIN;
    pixel_queue.push_back(it);
    pixel_queue.push_back(it);
    // The sender holds off here until every result has come back.
    wait_idle();
    // A wider two-row frame with extreme coefficients, subtract and min.
    setup(MERGE_SUB, REDUCE_MIN, 11'd40, 16'd2, 24'h7F7F7F, 24'h808080, 24'h7F7F7F);
    queue_frame(1'b0);

    // Random frames; mostly small sizes.
    while (real_items < 1150) begin
      if (real_items > 950) quiet = 1'b1;
      setup(2'($urandom_range(0, 3)), 3'($urandom_range(0, 7)),
            ($urandom_range(0, 9) == 0) ? 11'($urandom_range(0, 40))
                                        : 11'($urandom_range(1, 8)),
            16'($urandom_range(0, 6)), 24'($urandom), 24'($urandom), 24'($urandom));
      queue_frame(1'b1);
    end
    wait_idle();

    if (fail_count == 0) begin
      $display("tb_window_filter_3x3 OK");
    end else begin
      $display("tb_window_filter_3x3 NOT OK");
    end
    $finish;
  end

  // Run time limit.
  initial begin
    #20ms;
    $display("tb_window_filter_3x3 NOT OK");
    $finish;
  end

endmodule

`default_nettype wire
